// File: design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the load-cell calibration block
// Holds the point layout, the config register indexes and the queue item.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int ADC_W     = 12;
    localparam int GRAM_W    = 16;
    localparam int POINT_W   = 28;
    localparam int CFG_NUM   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = GRAM_W;

    typedef logic [POINT_W-1:0] t_point;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FIVE  = 3'd4;

    localparam t_point PT_RESET [CFG_NUM] = '{
        28'd292, 28'd475636, 28'd832151, 28'd1229642, 28'd1639437
    };

    // classified sample handed from front to back
    typedef struct packed {
        logic                     direct;   // base is the final answer
        logic [GRAM_W-1:0]        base;     // lower gram value or clamp value
        logic [ADC_W-1:0]         off;      // count minus segment start
        logic [ADC_W-1:0]         width;    // segment width in counts
        logic signed [GRAM_W:0]   dg;       // gram rise over the segment
    } t_item;

endpackage

// File: design/plc_adc_if.sv
// ----------------------------------------------------------------------------
// plc_adc_if: sample channel
// Carries one ADC count per beat with valid/ready flow control.
// ----------------------------------------------------------------------------
interface plc_adc_if;
    logic                      valid;
    logic                      ready;
    logic [plc_pkg::ADC_W-1:0] raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink   (input valid, input raw_count, output ready);
endinterface

// File: design/plc_weight_if.sv
// ----------------------------------------------------------------------------
// plc_weight_if: weight channel
// Carries one weight in grams per beat with valid/ready flow control.
// ----------------------------------------------------------------------------
interface plc_weight_if;
    logic                       valid;
    logic                       ready;
    logic [plc_pkg::GRAM_W-1:0] weight_grams;

    modport source (output valid, output weight_grams, input ready);
    modport sink   (input valid, input weight_grams, output ready);
endinterface

// File: design/piecewise_linear_calibration.sv
// ----------------------------------------------------------------------------
// piecewise_linear_calibration: load-cell count to grams
// Top level: front classification, item queue and arithmetic back end.
// ----------------------------------------------------------------------------
// Takes one 12-bit ADC count per beat and returns one weight in grams per beat,
// in order, at one sample per clock while the output is not stalled. The path
// is one front register, one queue slot, a multiply stage, a divide setup stage,
// 16 divide stages (one quotient bit each) and the output register, most of it
// the divide pipe. Points are to be written through the config port while the
// block is idle; the block itself does not enforce this. Point index 0..4 maps
// to register bits ADC count 11:0, grams 27:12.
module piecewise_linear_calibration #(
    parameter int CAL_POINTS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [plc_pkg::POINT_W-1:0]   i_cfg_data,
    plc_adc_if.sink                       i_sample,
    plc_weight_if.source                  o_weight
);

    logic           f_v, q_full, q_empty, pop;
    plc_pkg::t_item f_item, q_item;

    plc_front #(.CAL_POINTS(CAL_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_sample.valid),
        .o_ready     (i_sample.ready),
        .i_raw_count (i_sample.raw_count),
        .o_valid     (f_v),
        .i_ready     (!q_full),
        .o_item      (f_item)
    );

    plc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_v && !q_full),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    plc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_valid        (o_weight.valid),
        .i_ready        (o_weight.ready),
        .o_weight_grams (o_weight.weight_grams)
    );

endmodule

// File: design/plc_front.sv
// ----------------------------------------------------------------------------
// plc_front: calibration registers and segment classification
// Holds the points, finds the segment of each sample and registers the item.
// ----------------------------------------------------------------------------
module plc_front #(
    parameter int CAL_POINTS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [plc_pkg::POINT_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [plc_pkg::ADC_W-1:0]     i_raw_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output plc_pkg::t_item                o_item
);

    plc_pkg::t_point r_pt [CAL_POINTS];
    logic            r_v;
    plc_pkg::t_item  r_item;
    plc_pkg::t_item  n_item;

    // point registers; points past the last config register keep their reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAL_POINTS; i++) begin
            if (!i_rst_n) begin
                r_pt[i] <= plc_pkg::PT_RESET[(i < plc_pkg::CFG_NUM) ? i : plc_pkg::CFG_NUM-1];
            end else if (i_cfg_we && int'(i_cfg_idx) == i && i < plc_pkg::CFG_NUM) begin
                r_pt[i] <= i_cfg_data;
            end
        end
    end

    // classify: clamp low, clamp high, first matching segment (direct if zero width), or no match
    always_comb begin
        logic                      found;
        logic [plc_pkg::ADC_W-1:0] a0, a1;
        logic [plc_pkg::GRAM_W-1:0] g0, g1;
        found = 1'b0;
        a0 = '0; a1 = '0; g0 = '0; g1 = '0;
        for (int i = CAL_POINTS-2; i >= 0; i--) begin
            if (i_raw_count >= r_pt[i][11:0] && i_raw_count <= r_pt[i+1][11:0]) begin
                found = 1'b1;
                a0 = r_pt[i][11:0];
                a1 = r_pt[i+1][11:0];
                g0 = r_pt[i][27:12];
                g1 = r_pt[i+1][27:12];
            end
        end
        n_item.off   = i_raw_count - a0;
        n_item.width = a1 - a0;
        n_item.dg    = $signed({1'b0, g1}) - $signed({1'b0, g0});
        n_item.base  = g0;
        n_item.direct = 1'b0;
        if (i_raw_count <= r_pt[0][11:0]) begin
            n_item.direct = 1'b1;
            n_item.base   = r_pt[0][27:12];
        end else if (i_raw_count >= r_pt[CAL_POINTS-1][11:0]) begin
            n_item.direct = 1'b1;
            n_item.base   = r_pt[CAL_POINTS-1][27:12];
        end else if (!found) begin
            n_item.direct = 1'b1;
            n_item.base   = '0;
        end else if (a1 == a0) begin
            n_item.direct = 1'b1;
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: design/plc_queue.sv
// ----------------------------------------------------------------------------
// plc_queue: two-entry queue between classification and arithmetic
// Lets the front keep taking samples while the back is stalled, until both entries are full.
// ----------------------------------------------------------------------------
module plc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output plc_pkg::t_item o_item
);

    plc_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: design/plc_back.sv
// ----------------------------------------------------------------------------
// plc_back: interpolation arithmetic
// Multiply, then a pipelined restoring divide (one quotient bit a stage),
// then the signed add to the lower gram value. The whole pipe stalls together.
// ----------------------------------------------------------------------------
module plc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  plc_pkg::t_item             i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [plc_pkg::GRAM_W-1:0] o_weight_grams
);

    localparam int N = plc_pkg::DIV_STEPS;

    logic en;

    // multiply stage
    logic                        r_m_v, r_m_direct;
    logic [plc_pkg::GRAM_W-1:0]  r_m_base;
    logic [plc_pkg::ADC_W-1:0]   r_m_width;
    logic signed [29:0]          r_m_prod;

    // divide stages: index 0 is the setup stage, N the last quotient bit
    logic                        r_d_v      [N+1];
    logic                        r_d_direct [N+1];
    logic                        r_d_neg    [N+1];
    logic [plc_pkg::GRAM_W-1:0]  r_d_base   [N+1];
    logic [plc_pkg::ADC_W-1:0]   r_d_width  [N+1];
    logic [plc_pkg::ADC_W-1:0]   r_d_rem    [N+1];
    logic [N-1:0]                r_d_low    [N+1];
    logic [N-1:0]                r_d_q      [N+1];

    // output register
    logic                        r_o_v;
    logic [plc_pkg::GRAM_W-1:0]  r_o_w;

    logic [29:0]                 mag;
    logic [plc_pkg::GRAM_W-1:0]  n_w;

    assign en    = !r_o_v || i_ready;
    assign o_pop = en && !i_empty;
    assign mag   = r_m_prod[29] ? 30'(-r_m_prod) : 30'(r_m_prod);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k <= N; k++) r_d_v[k] <= 1'b0;
        end else if (en) begin
            r_m_v    <= !i_empty;
            r_d_v[0] <= r_m_v;
            for (int k = 1; k <= N; k++) r_d_v[k] <= r_d_v[k-1];
            r_o_v    <= r_d_v[N];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        logic [plc_pkg::ADC_W:0] trial;
        if (en) begin
            r_m_direct <= i_item.direct;
            r_m_base   <= i_item.base;
            r_m_width  <= i_item.width;
            r_m_prod   <= $signed({1'b0, i_item.off}) * $signed(i_item.dg);

            r_d_direct[0] <= r_m_direct;
            r_d_neg[0]    <= r_m_prod[29];
            r_d_base[0]   <= r_m_base;
            r_d_width[0]  <= r_m_width;
            r_d_rem[0]    <= mag[27:16];
            r_d_low[0]    <= mag[15:0];
            r_d_q[0]      <= '0;

            for (int k = 1; k <= N; k++) begin
                trial = {r_d_rem[k-1], r_d_low[k-1][N-k]};
                r_d_direct[k] <= r_d_direct[k-1];
                r_d_neg[k]    <= r_d_neg[k-1];
                r_d_base[k]   <= r_d_base[k-1];
                r_d_width[k]  <= r_d_width[k-1];
                r_d_low[k]    <= r_d_low[k-1];
                if (trial >= {1'b0, r_d_width[k-1]}) begin
                    r_d_rem[k] <= 12'(trial - {1'b0, r_d_width[k-1]});
                    r_d_q[k]   <= r_d_q[k-1] | (N'(1) << (N-k));
                end else begin
                    r_d_rem[k] <= trial[plc_pkg::ADC_W-1:0];
                    r_d_q[k]   <= r_d_q[k-1];
                end
            end
            r_o_w <= n_w;
        end
    end

    // final add; a matched segment always lands between its gram values
    always_comb begin
        if (r_d_direct[N]) begin
            n_w = r_d_base[N];
        end else if (r_d_neg[N]) begin
            n_w = r_d_base[N] - r_d_q[N];
        end else begin
            n_w = r_d_base[N] + r_d_q[N];
        end
    end

    assign o_valid        = r_o_v;
    assign o_weight_grams = r_o_w;

endmodule

// File: design/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker: port-level checks for the calibration block
// Reset behavior and output beat stability under backpressure.
// ----------------------------------------------------------------------------
module plc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [plc_pkg::GRAM_W-1:0] i_out_w
);

    // no result right after reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input side open right after reset
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

    // stalled beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_w))
        else $error("output beat changed while stalled");

endmodule

bind piecewise_linear_calibration plc_checker u_plc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_weight.valid),
    .i_out_ready (o_weight.ready),
    .i_out_w     (o_weight.weight_grams)
);

// File: tb/plc_tb_chan_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plc_tb_chan_if: testbench package plc_tb_pkg
// The channel interfaces come from the design; this file holds only the stimulus row type.
// ----------------------------------------------------------------------------
package plc_tb_pkg;

    // one directed stimulus row: optional typed-in answer
    typedef struct {
        logic [11:0] count;
        logic        known;
        logic [15:0] grams;
    } t_row;

endpackage

// File: tb/piecewise_linear_calibration_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_tb: self-checking bench for the calibration
// Drives ADC counts under several point sets, predicts grams by interpolation
// and compares every output beat in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_tb;

    localparam int LATENCY   = 21;
    localparam int WDOG_MAX  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [plc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [plc_pkg::POINT_W-1:0] i_cfg_data = '0;

    plc_adc_if    adc_ch ();
    plc_weight_if wt_ch ();

    piecewise_linear_calibration #(.CAL_POINTS(5)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_sample(adc_ch.sink), .o_weight(wt_ch.source)
    );

    always #2 i_clk = ~i_clk;

    plc_pkg::t_point cal_pts [plc_pkg::CFG_NUM];
    logic [15:0] grams_due [$];
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int src_idle = 0;
    int snk_idle = 0;
    bit hold_sink = 0;
    int idle_cnt = 0;

    initial begin
        adc_ch.valid = 1'b0;
        adc_ch.raw_count = '0;
        wt_ch.ready = 1'b0;
    end

    // interpolate one count against the current points
    function automatic logic [15:0] grams_of(logic [11:0] x);
        longint a0, a1, g0, g1, r;
        if (x <= cal_pts[0][11:0]) return cal_pts[0][27:12];
        if (x >= cal_pts[plc_pkg::CFG_NUM-1][11:0]) return cal_pts[plc_pkg::CFG_NUM-1][27:12];
        for (int i = 0; i < plc_pkg::CFG_NUM - 1; i++) begin
            a0 = cal_pts[i][11:0];
            a1 = cal_pts[i+1][11:0];
            if (x >= a0 && x <= a1) begin
                g0 = cal_pts[i][27:12];
                g1 = cal_pts[i+1][27:12];
                if (a1 == a0) return g0[15:0];
                r = g0 + ((longint'(x) - a0) * (g1 - g0)) / (a1 - a0);
                if (r < 0) r = 0;
                if (r > 65535) r = 65535;
                return r[15:0];
            end
        end
        return 16'd0;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, n_out);
    endtask

    // output side: random ready, check beats in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (wt_ch.valid && wt_ch.ready) begin
                n_out++;
                if (grams_due.size() == 0)
                    report_mismatch("unexpected beat", wt_ch.weight_grams, 16'd0);
                else if (wt_ch.weight_grams !== grams_due[0])
                    report_mismatch("weight_grams", wt_ch.weight_grams, grams_due[0]);
                if (grams_due.size() != 0) void'(grams_due.pop_front());
            end
            wt_ch.ready <= !hold_sink && ($urandom_range(99) >= snk_idle);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((adc_ch.valid && adc_ch.ready) || (wt_ch.valid && wt_ch.ready))
            idle_cnt <= 0;
        else if (i_rst_n) begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_MAX) begin
                $display("watchdog expired with %0d beats outstanding", grams_due.size());
                $display("FAIL piecewise_linear_calibration");
                $finish;
            end
        end
    end

    // one input beat; valid stays high across back-to-back beats
    task automatic send_count(logic [11:0] x, logic known, logic [15:0] want);
        while ($urandom_range(99) < src_idle) begin
            adc_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        adc_ch.valid <= 1'b1;
        adc_ch.raw_count <= x;
        @(posedge i_clk);
        while (!adc_ch.ready) @(posedge i_clk);
        grams_due.push_back(known ? want : grams_of(x));
        n_in++;
    endtask

    task automatic drain();
        adc_ch.valid <= 1'b0;
        while (grams_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // one write beat, after which the enable is brought low again
    task automatic write_point(logic [plc_pkg::CFG_IDX_W-1:0] idx, logic [11:0] cnt,
                               logic [15:0] g);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= {g, cnt};
        cal_pts[idx] = {g, cnt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ascending random set, occasionally with ties or out of order
    task automatic random_points(int style);
        logic [11:0] c [plc_pkg::CFG_NUM];
        logic [15:0] g [plc_pkg::CFG_NUM];
        for (int i = 0; i < plc_pkg::CFG_NUM; i++) begin
            c[i] = 12'($urandom_range(4095));
            g[i] = 16'($urandom_range(65535));
        end
        if (style != 2) c.sort();
        if (style == 1) c[2] = c[1];
        for (int i = 0; i < plc_pkg::CFG_NUM; i++)
            write_point(plc_pkg::CFG_IDX_W'(i), c[i], g[i]);
    endtask

    task automatic random_burst(int cnt);
        logic [11:0] x;
        for (int i = 0; i < cnt; i++) begin
            case ($urandom_range(3))
                0: x = 12'($urandom_range(4095));
                1: x = cal_pts[$urandom_range(plc_pkg::CFG_NUM-1)][11:0];
                default: x = 12'($urandom_range(cal_pts[plc_pkg::CFG_NUM-1][11:0],
                                                cal_pts[0][11:0]));
            endcase
            send_count(x, 1'b0, 16'd0);
        end
    endtask

    plc_tb_pkg::t_row rows [$];

    initial begin
        cal_pts = plc_pkg::PT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under the reset points
        rows = '{
            '{12'd0,    1'b1, 16'd0},   '{12'd292,  1'b1, 16'd0},
            '{12'd500,  1'b1, 16'd116}, '{12'd663,  1'b1, 16'd203},
            '{12'd842,  1'b1, 16'd300}, '{12'd1037, 1'b1, 16'd400},
            '{12'd4095, 1'b1, 16'd400}, '{12'd293,  1'b0, 16'd0},
            '{12'd400,  1'b0, 16'd0},   '{12'd600,  1'b0, 16'd0},
            '{12'd750,  1'b0, 16'd0},   '{12'd1036, 1'b0, 16'd0},
            '{12'd2730, 1'b1, 16'd400}, '{12'd1365, 1'b1, 16'd400}
        };
        foreach (rows[i]) send_count(rows[i].count, rows[i].known, rows[i].grams);
        drain();

        // extremes: full-range gram span and a zero-width segment
        write_point(plc_pkg::REG_POINT_ONE,   12'd0,    16'd0);
        write_point(plc_pkg::REG_POINT_TWO,   12'd1,    16'hFFFF);
        write_point(plc_pkg::REG_POINT_THREE, 12'd1,    16'd5);
        write_point(plc_pkg::REG_POINT_FOUR,  12'd4094, 16'd0);
        write_point(plc_pkg::REG_POINT_FIVE,  12'd4095, 16'hFFFF);
        rows = '{
            '{12'd0, 1'b1, 16'd0}, '{12'd1, 1'b1, 16'hFFFF},
            '{12'd4095, 1'b1, 16'hFFFF}, '{12'd2048, 1'b0, 16'd0},
            '{12'd4094, 1'b1, 16'd0}, '{12'd2, 1'b0, 16'd0}
        };
        foreach (rows[i]) send_count(rows[i].count, rows[i].known, rows[i].grams);
        drain();

        // points not ascending: the first segment that holds the count wins
        write_point(plc_pkg::REG_POINT_ONE,   12'd100,  16'd10);
        write_point(plc_pkg::REG_POINT_TWO,   12'd3000, 16'd20);
        write_point(plc_pkg::REG_POINT_THREE, 12'd200,  16'd30);
        write_point(plc_pkg::REG_POINT_FOUR,  12'd150,  16'd40);
        write_point(plc_pkg::REG_POINT_FIVE,  12'd4000, 16'd50);
        send_count(12'd3500, 1'b0, 16'd0);
        send_count(12'd50, 1'b1, 16'd10);
        send_count(12'd4095, 1'b1, 16'd50);
        drain();

        // random phases with changing points and idling mixes
        for (int ph = 0; ph < 12; ph++) begin
            random_points(ph % 4 == 3 ? 2 : ph % 4 == 2);
            if (ph < 4) begin src_idle = 29; snk_idle = 59; end
            else if (ph < 8) begin src_idle = 59; snk_idle = 29; end
            else begin src_idle = 0; snk_idle = 0; end
            if (ph == 9) begin
                // receiver holds off long so the block backs up its input
                fork
                    begin
                        hold_sink = 1;
                        repeat (200) @(posedge i_clk);
                        hold_sink = 0;
                    end
                    random_burst(80);
                join
            end else begin
                random_burst(80);
            end
            drain();
        end
        src_idle = 0;
        snk_idle = 0;
        drain();

        $display("covered %0d samples and %0d weights over 15 point sets,", n_in, n_out);
        $display("including tied and unordered points and long output stalls");
        if (errors == 0)
            $display("PASS piecewise_linear_calibration");
        else
            $display("FAIL piecewise_linear_calibration");
        $finish;
    end

endmodule

// File: files.f
design/plc_pkg.sv
design/plc_adc_if.sv
design/plc_weight_if.sv
design/plc_front.sv
design/plc_queue.sv
design/plc_back.sv
design/piecewise_linear_calibration.sv
design/plc_checker.sv
tb/plc_tb_chan_if.sv
tb/piecewise_linear_calibration_tb.sv
